// ===== hdl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure / temperature compensation
// pipeline: beat structs, register indexes, divider width and coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

    // Datapath and divider width
    localparam int DIV_W = 32;

    // Configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;

    // Sideband widths carried through the two dividers
    localparam int DIV1_SIDE_W = DIV_W + 2 + 16;
    localparam int DIV2_SIDE_W = 2 + 16;

    // Compensation coefficients
    localparam logic [31:0] C_4000   = 32'd4000;
    localparam logic [31:0] C_50000  = 32'd50000;
    localparam logic [31:0] C_3038   = 32'd3038;
    localparam logic [31:0] C_M7357  = 32'hFFFF_E343;
    localparam logic [31:0] C_3791   = 32'd3791;
    localparam logic [31:0] C_32768  = 32'd32768;
    localparam logic [31:0] C_8      = 32'd8;
    localparam logic [31:0] C_2      = 32'd2;
    localparam logic [31:0] C_P_MAX  = 32'd1048575;
    localparam logic [31:0] C_T_MAX  = 32'd32767;
    localparam logic [31:0] C_T_MIN  = 32'hFFFF_8000;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] raw_pressure;
    } t_in;

    typedef struct packed {
        logic signed [15:0] temp_tenths;
        logic [19:0]        pressure_pa;
        logic               div_error;
    } t_out;

endpackage

`default_nettype wire

// ===== hdl/ptc_div.sv =====
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined unsigned restoring divider: one quotient bit per stage, a new
// beat every cycle, sideband bits carried alongside the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_div #(
    parameter int SIDE_W = ptc_pkg::DIV1_SIDE_W
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [ptc_pkg::DIV_W-1:0]  i_num,
    input  wire logic [ptc_pkg::DIV_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0]          i_side,
    output logic                            o_valid,
    output logic [ptc_pkg::DIV_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]               o_side
);

    localparam int W = ptc_pkg::DIV_W;

    logic [W-1:0]      r_rem  [W];
    logic [W-1:0]      r_num  [W];
    logic [W-1:0]      r_den  [W];
    logic [SIDE_W-1:0] r_side [W];
    logic [W-1:0]      r_vld;

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_stage
            logic [W-1:0]      prev_rem;
            logic [W-1:0]      prev_num;
            logic [W-1:0]      prev_den;
            logic [SIDE_W-1:0] prev_side;
            logic              prev_vld;
            logic [W:0]        trial;
            logic [W:0]        diff;
            logic              ge;

            if (k == 0) begin : g_first
                assign prev_rem  = '0;
                assign prev_num  = i_num;
                assign prev_den  = i_den;
                assign prev_side = i_side;
                assign prev_vld  = i_valid;
            end else begin : g_next
                assign prev_rem  = r_rem[k-1];
                assign prev_num  = r_num[k-1];
                assign prev_den  = r_den[k-1];
                assign prev_side = r_side[k-1];
                assign prev_vld  = r_vld[k-1];
            end

            // Shift in next dividend bit and try a subtract
            assign trial = {prev_rem, prev_num[W-1]};
            assign diff  = trial - {1'b0, prev_den};
            assign ge    = (trial >= {1'b0, prev_den});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= prev_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
                r_num[k]  <= {prev_num[W-2:0], ge};
                r_den[k]  <= prev_den;
                r_side[k] <= prev_side;
            end
        end
    endgenerate

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_num[W-1];
    assign o_side  = r_side[W-1];

endmodule

`default_nettype wire

// ===== hdl/pressure_temperature_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Integer compensation of raw temperature and pressure readings (oss 0)
// into 0.1 degC and Pa, with zero-divisor flag and output saturation.
// ----------------------------------------------------------------------------
//
//  channel  | handshake         | payload            | direction
//  ---------+-------------------+--------------------+----------
//  input    | start / busy      | i_in   (t_in)      | in
//  result   | o_valid strobe    | o_out  (t_out)     | out
//  config   | i_cfg_we          | i_cfg_idx/i_cfg_data | in
//
//  A beat is accepted on every cycle with start high; busy stays low.
//  Two 32-stage bit-per-cycle dividers make up most of the pipeline,
//  with 20 arithmetic stages around them.
//  Reset clears the valid chain and the calibration registers.
//  The receiver cannot stall; one result beat per accepted input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire ptc_pkg::t_in                  i_in,
    output logic                               o_valid,
    output ptc_pkg::t_out                      o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [ptc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ptc_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int W   = ptc_pkg::DIV_W;
    localparam int LAT = 20 + 2 * ptc_pkg::DIV_W;

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [31:0] r_cal_ac1_ac2, r_cal_ac3_ac4, r_cal_ac5_ac6, r_cal_b1_b2, r_cal_mc_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_ac1_ac2 <= '0;
            r_cal_ac3_ac4 <= '0;
            r_cal_ac5_ac6 <= '0;
            r_cal_b1_b2   <= '0;
            r_cal_mc_md   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptc_pkg::REG_AC1_AC2: r_cal_ac1_ac2 <= i_cfg_data;
                ptc_pkg::REG_AC3_AC4: r_cal_ac3_ac4 <= i_cfg_data;
                ptc_pkg::REG_AC5_AC6: r_cal_ac5_ac6 <= i_cfg_data;
                ptc_pkg::REG_B1_B2:   r_cal_b1_b2   <= i_cfg_data;
                ptc_pkg::REG_MC_MD:   r_cal_mc_md   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack calibration words to 32-bit operands
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{r_cal_ac1_ac2[31]}}, r_cal_ac1_ac2[31:16]};
    assign ac2 = {{16{r_cal_ac1_ac2[15]}}, r_cal_ac1_ac2[15:0]};
    assign ac3 = {{16{r_cal_ac3_ac4[31]}}, r_cal_ac3_ac4[31:16]};
    assign ac4 = {16'd0, r_cal_ac3_ac4[15:0]};
    assign ac5 = {16'd0, r_cal_ac5_ac6[31:16]};
    assign ac6 = {16'd0, r_cal_ac5_ac6[15:0]};
    assign b1  = {{16{r_cal_b1_b2[31]}}, r_cal_b1_b2[31:16]};
    assign b2  = {{16{r_cal_b1_b2[15]}}, r_cal_b1_b2[15:0]};
    assign mc  = {{16{r_cal_mc_md[31]}}, r_cal_mc_md[31:16]};
    assign md  = {{16{r_cal_mc_md[15]}}, r_cal_mc_md[15:0]};

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Valid chain outside the dividers
    // ------------------------------------------------------------------
    logic r_v0, r_v1, r_v2, r_v3;
    logic r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10, r_v11, r_v12, r_v13;
    logic r_v15, r_v16, r_v17, r_v18, r_v19, r_v20;
    logic d1_valid, d2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0; r_v1  <= 1'b0; r_v2  <= 1'b0; r_v3  <= 1'b0;
            r_v4  <= 1'b0; r_v5  <= 1'b0; r_v6  <= 1'b0; r_v7  <= 1'b0;
            r_v8  <= 1'b0; r_v9  <= 1'b0; r_v10 <= 1'b0; r_v11 <= 1'b0;
            r_v12 <= 1'b0; r_v13 <= 1'b0;
            r_v15 <= 1'b0; r_v16 <= 1'b0; r_v17 <= 1'b0; r_v18 <= 1'b0;
            r_v19 <= 1'b0; r_v20 <= 1'b0;
        end else begin
            r_v0  <= start & ~busy;
            r_v1  <= r_v0;  r_v2  <= r_v1;  r_v3  <= r_v2;
            r_v4  <= d1_valid;
            r_v5  <= r_v4;  r_v6  <= r_v5;  r_v7  <= r_v6;  r_v8  <= r_v7;
            r_v9  <= r_v8;  r_v10 <= r_v9;  r_v11 <= r_v10; r_v12 <= r_v11;
            r_v13 <= r_v12;
            r_v15 <= d2_valid;
            r_v16 <= r_v15; r_v17 <= r_v16; r_v18 <= r_v17; r_v19 <= r_v18;
            r_v20 <= r_v19;
        end
    end

    // ------------------------------------------------------------------
    // Temperature path up to the first divider
    // ------------------------------------------------------------------
    logic [15:0] r_ut0, r_up0, r_up1, r_up2, r_up3;
    logic [31:0] r_prod1, r_x1_2, r_den2, r_x1_3, r_ma3, r_mb3;
    logic        r_neg3, r_zero3;
    logic [31:0] n_diff1, n_mcsh2;

    assign n_diff1 = {16'd0, r_ut0} - ac6;
    assign n_mcsh2 = {mc[20:0], 11'd0};

    always_ff @(posedge i_clk) begin
        // capture beat
        r_ut0   <= i_in.raw_temp;
        r_up0   <= i_in.raw_pressure;
        // (ut - ac6) * ac5
        r_prod1 <= 32'(n_diff1 * ac5);
        r_up1   <= r_up0;
        // x1 and divisor
        r_x1_2  <= 32'($signed(r_prod1) >>> 15);
        r_den2  <= 32'($signed(r_prod1) >>> 15) + md;
        r_up2   <= r_up1;
        // take magnitudes for the signed divide
        r_ma3   <= n_mcsh2[31] ? 32'(0 - n_mcsh2) : n_mcsh2;
        r_mb3   <= r_den2[31] ? 32'(0 - r_den2) : r_den2;
        r_neg3  <= n_mcsh2[31] ^ r_den2[31];
        r_zero3 <= (r_den2 == '0);
        r_x1_3  <= r_x1_2;
        r_up3   <= r_up2;
    end

    logic [W-1:0]                       d1_quo;
    logic [ptc_pkg::DIV1_SIDE_W-1:0]    d1_side;

    ptc_div #(
        .SIDE_W (ptc_pkg::DIV1_SIDE_W)
    ) u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_num   (r_ma3),
        .i_den   (r_mb3),
        .i_side  ({r_x1_3, r_neg3, r_zero3, r_up3}),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // ------------------------------------------------------------------
    // B5 through B7
    // ------------------------------------------------------------------
    logic [31:0] d1_x1;
    logic        d1_neg, d1_zero;
    logic [15:0] d1_up;
    assign {d1_x1, d1_neg, d1_zero, d1_up} = d1_side;

    logic [31:0] r_x2_4, r_x1_4, r_b5_5, r_b6_6;
    logic [15:0] r_t6;
    logic [31:0] r_sqp7, r_ac2b6_7, r_ac3b6_7;
    logic [31:0] r_sq8, r_x2a8, r_x1b8;
    logic [31:0] r_b2sq9, r_b1sq9, r_x2a9, r_x1b9;
    logic [31:0] r_b3n10, r_x3b10, r_b3_11, r_x3c11;
    logic [31:0] r_b4_12, r_b7a12, r_b4_13, r_b7_13;
    logic [15:0] r_up4, r_up5, r_up6, r_up7, r_up8, r_up9, r_up10, r_up10_d;
    logic [15:0] r_t7, r_t8, r_t9, r_t10, r_t11, r_t12, r_t13;
    logic        r_z4, r_z5, r_z6, r_z7, r_z8, r_z9, r_z10, r_z11, r_z12, r_z13;
    logic [31:0] n_t5, n_x1a9, n_x2b9, n_b3r10;
    logic [15:0] n_tsat5;

    assign n_t5    = 32'($signed(r_b5_5 + ptc_pkg::C_8) >>> 4);
    assign n_tsat5 = ($signed(n_t5) > $signed(ptc_pkg::C_T_MAX)) ? ptc_pkg::C_T_MAX[15:0] :
                     ($signed(n_t5) < $signed(ptc_pkg::C_T_MIN)) ? ptc_pkg::C_T_MIN[15:0] :
                     n_t5[15:0];
    assign n_x1a9  = 32'($signed(r_b2sq9) >>> 11);
    assign n_x2b9  = 32'($signed(r_b1sq9) >>> 16);
    assign n_b3r10 = r_b3n10 + (r_b3n10[31] ? 32'd3 : 32'd0);

    always_ff @(posedge i_clk) begin
        // apply quotient sign
        r_x2_4    <= d1_neg ? 32'(0 - d1_quo) : d1_quo;
        r_x1_4    <= d1_x1;
        r_z4      <= d1_zero;
        r_up4     <= d1_up;
        // b5
        r_b5_5    <= r_x1_4 + r_x2_4;
        r_z5      <= r_z4;
        r_up5     <= r_up4;
        // b6 and saturated temperature
        r_b6_6    <= r_b5_5 - ptc_pkg::C_4000;
        r_t6      <= n_tsat5;
        r_z6      <= r_z5;
        r_up6     <= r_up5;
        // products on b6
        r_sqp7    <= 32'(r_b6_6 * r_b6_6);
        r_ac2b6_7 <= 32'(ac2 * r_b6_6);
        r_ac3b6_7 <= 32'(ac3 * r_b6_6);
        r_t7      <= r_t6;
        r_z7      <= r_z6;
        r_up7     <= r_up6;
        // shifts
        r_sq8     <= 32'($signed(r_sqp7) >>> 12);
        r_x2a8    <= 32'($signed(r_ac2b6_7) >>> 11);
        r_x1b8    <= 32'($signed(r_ac3b6_7) >>> 13);
        r_t8      <= r_t7;
        r_z8      <= r_z7;
        r_up8     <= r_up7;
        // products on sq
        r_b2sq9   <= 32'(b2 * r_sq8);
        r_b1sq9   <= 32'(b1 * r_sq8);
        r_x2a9    <= r_x2a8;
        r_x1b9    <= r_x1b8;
        r_t9      <= r_t8;
        r_z9      <= r_z8;
        r_up9     <= r_up8;
        // b3 numerator and x3
        r_b3n10   <= {ac1[29:0], 2'b00} + n_x1a9 + r_x2a9 + ptc_pkg::C_2;
        r_x3b10   <= 32'($signed(r_x1b9 + n_x2b9 + ptc_pkg::C_2) >>> 2);
        r_t10     <= r_t9;
        r_z10     <= r_z9;
        r_up10    <= r_up9;
        // b3 truncated toward zero
        r_b3_11   <= 32'($signed(n_b3r10) >>> 2);
        r_x3c11   <= r_x3b10 + ptc_pkg::C_32768;
        r_t11     <= r_t10;
        r_z11     <= r_z10;
        // b4 and b7 difference; up joins b3 here
        r_b4_12   <= 32'(ac4 * r_x3c11) >> 15;
        r_b7a12   <= {16'd0, r_up10_d} - r_b3_11;
        r_t12     <= r_t11;
        r_z12     <= r_z11;
        // b7
        r_b7_13   <= 32'(r_b7a12 * ptc_pkg::C_50000);
        r_b4_13   <= r_b4_12;
        r_t13     <= r_t12;
        r_z13     <= r_z12 | (r_b4_12 == '0);
    end

    // Hold raw pressure one more stage to line up with b3
    always_ff @(posedge i_clk) begin
        r_up10_d <= r_up10;
    end

    // ------------------------------------------------------------------
    // Pressure divide
    // ------------------------------------------------------------------
    logic [W-1:0]                    d2_quo;
    logic [ptc_pkg::DIV2_SIDE_W-1:0] d2_side;
    logic [W-1:0]                    n_num13;

    assign n_num13 = r_b7_13[31] ? r_b7_13 : {r_b7_13[30:0], 1'b0};

    ptc_div #(
        .SIDE_W (ptc_pkg::DIV2_SIDE_W)
    ) u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v13),
        .i_num   (n_num13),
        .i_den   (r_b4_13),
        .i_side  ({r_b7_13[31], r_z13, r_t13}),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // ------------------------------------------------------------------
    // Final pressure correction and output
    // ------------------------------------------------------------------
    logic        d2_sel, d2_err;
    logic [15:0] d2_t;
    assign {d2_sel, d2_err, d2_t} = d2_side;

    logic [31:0] r_p15, r_p16, r_p17, r_p18, r_p19;
    logic [31:0] r_x1p16, r_x2p16, r_x1c17, r_x2_17, r_s18;
    logic [15:0] r_t15, r_t16, r_t17, r_t18, r_t19;
    logic        r_e15, r_e16, r_e17, r_e18, r_e19;
    logic [31:0] n_hi15;
    ptc_pkg::t_out r_out;

    assign n_hi15 = 32'($signed(r_p15) >>> 8);

    always_ff @(posedge i_clk) begin
        // double the quotient when the dividend was not shifted
        r_p15   <= d2_sel ? {d2_quo[30:0], 1'b0} : d2_quo;
        r_t15   <= d2_t;
        r_e15   <= d2_err;
        // square of p/256 and linear term
        r_x1p16 <= 32'(n_hi15 * n_hi15);
        r_x2p16 <= 32'(ptc_pkg::C_M7357 * r_p15);
        r_p16   <= r_p15;
        r_t16   <= r_t15;
        r_e16   <= r_e15;
        // scale
        r_x1c17 <= 32'(r_x1p16 * ptc_pkg::C_3038);
        r_x2_17 <= 32'($signed(r_x2p16) >>> 16);
        r_p17   <= r_p16;
        r_t17   <= r_t16;
        r_e17   <= r_e16;
        // sum of corrections
        r_s18   <= 32'($signed(r_x1c17) >>> 16) + r_x2_17 + ptc_pkg::C_3791;
        r_p18   <= r_p17;
        r_t18   <= r_t17;
        r_e18   <= r_e17;
        // corrected pressure
        r_p19   <= r_p18 + 32'($signed(r_s18) >>> 4);
        r_t19   <= r_t18;
        r_e19   <= r_e18;
    end

    // Saturate pressure, zero results on a divide error
    always_ff @(posedge i_clk) begin
        r_out.div_error <= r_e19;
        if (r_e19) begin
            r_out.temp_tenths <= '0;
            r_out.pressure_pa <= '0;
        end else begin
            r_out.temp_tenths <= r_t19;
            if (r_p19[31]) begin
                r_out.pressure_pa <= '0;
            end else if (r_p19 > ptc_pkg::C_P_MAX) begin
                r_out.pressure_pa <= ptc_pkg::C_P_MAX[19:0];
            end else begin
                r_out.pressure_pa <= r_p19[19:0];
            end
        end
    end

    assign o_valid = r_v20;
    assign o_out   = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result beat without a matching input beat");

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.div_error) |-> (o_out.temp_tenths == '0 && o_out.pressure_pa == '0))
        else $error("divide error beat carries nonzero results");

    a_press_lane_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v13 |-> $past(r_v3, LAT - 2 * ptc_pkg::DIV_W - 10 + ptc_pkg::DIV_W))
        else $error("pressure lane out of step with temperature lane");

endmodule

`default_nettype wire

// ===== verif/pressure_temperature_compensation_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_checker
// Watches the config, input and result channels of the compensation unit.
// Computes the expected temperature, pressure and divide-error flag for each
// accepted reading pair and compares them in order with the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire ptc_pkg::t_in                  i_in,
    input  wire logic                          o_valid,
    input  wire ptc_pkg::t_out                 o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [ptc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ptc_pkg::CFG_W-1:0]     i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_results
);

    logic [31:0]   cal [0:4];
    ptc_pkg::t_out expected_q [$];

    // Arithmetic shift right on a 32-bit word
    function automatic logic [31:0] sra32(logic [31:0] v, int n);
        return 32'($signed(v) >>> n);
    endfunction

    // Signed divide truncating toward zero
    function automatic logic [31:0] sdiv32(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    // Compute the compensated result for one reading pair
    function automatic ptc_pkg::t_out compensate(ptc_pkg::t_in rd);
        ptc_pkg::t_out r;
        logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b7, sq, t, p;
        ut  = {16'd0, rd.raw_temp};
        up  = {16'd0, rd.raw_pressure};
        ac1 = sx16(cal[ptc_pkg::REG_AC1_AC2][31:16]);
        ac2 = sx16(cal[ptc_pkg::REG_AC1_AC2][15:0]);
        ac3 = sx16(cal[ptc_pkg::REG_AC3_AC4][31:16]);
        ac4 = {16'd0, cal[ptc_pkg::REG_AC3_AC4][15:0]};
        ac5 = {16'd0, cal[ptc_pkg::REG_AC5_AC6][31:16]};
        ac6 = {16'd0, cal[ptc_pkg::REG_AC5_AC6][15:0]};
        b1  = sx16(cal[ptc_pkg::REG_B1_B2][31:16]);
        b2  = sx16(cal[ptc_pkg::REG_B1_B2][15:0]);
        mc  = sx16(cal[ptc_pkg::REG_MC_MD][31:16]);
        md  = sx16(cal[ptc_pkg::REG_MC_MD][15:0]);
        r = '0;
        r.div_error = 1'b1;
        x1  = sra32((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = sdiv32(mc << 11, den);
        b5 = x1 + x2;
        t  = sra32(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        sq = sra32(b6 * b6, 12);
        x1 = sra32(b2 * sq, 11);
        x2 = sra32(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sdiv32(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
        x1 = sra32(ac3 * b6, 13);
        x2 = sra32(b1 * sq, 16);
        x3 = sra32(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * 32'd50000;
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else         p = (b7 / b4) * 32'd2;
        x1 = sra32(p, 8) * sra32(p, 8);
        x1 = sra32(x1 * 32'd3038, 16);
        x2 = sra32(32'hFFFF_E343 * p, 16);
        p  = p + sra32(x1 + x2 + 32'd3791, 4);
        if ($signed(t) > 32767)       r.temp_tenths = 16'sh7FFF;
        else if ($signed(t) < -32768) r.temp_tenths = 16'sh8000;
        else                          r.temp_tenths = t[15:0];
        if ($signed(p) < 0)                r.pressure_pa = '0;
        else if ($signed(p) > 1048575)     r.pressure_pa = 20'hFFFFF;
        else                               r.pressure_pa = p[19:0];
        r.div_error = 1'b0;
        return r;
    endfunction

    // Track config, queue predictions, compare result beats
    always @(posedge i_clk) begin
        ptc_pkg::t_out want;
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) cal[k] <= '0;
            expected_q.delete();
            o_errors  <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (o_valid) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result beat %p", $time, o_out);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (o_out.temp_tenths !== want.temp_tenths ||
                        o_out.pressure_pa !== want.pressure_pa ||
                        o_out.div_error !== want.div_error) begin
                        $display("%0t: expected t=%0d p=%0d e=%0b, got t=%0d p=%0d e=%0b",
                                 $time, want.temp_tenths, want.pressure_pa,
                                 want.div_error, o_out.temp_tenths,
                                 o_out.pressure_pa, o_out.div_error);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (start && !busy) expected_q.push_back(compensate(i_in));
            o_pending <= expected_q.size();
            if (i_cfg_we && i_cfg_idx < 5) cal[i_cfg_idx] <= i_cfg_data;
        end
    end

endmodule

`default_nettype wire

// ===== verif/pressure_temperature_compensation_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit_test
// Drives calibration sets and reading pairs, directed then random in bursts,
// into the compensation unit; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation_unit_test;

    localparam int LATENCY = 84;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    ptc_pkg::t_in                  i_in = '0;
    logic                          o_valid;
    ptc_pkg::t_out                 o_out;
    logic                          i_cfg_we = 1'b0;
    logic [ptc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [ptc_pkg::CFG_W-1:0]     i_cfg_data = '0;
    int                            errors, pending, results;
    int                            beats = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    pressure_temperature_compensation_unit u_dut (.*);

    pressure_temperature_compensation_checker u_chk (
        .i_clk, .i_rst_n, .start, .busy, .i_in, .o_valid, .o_out,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Present one reading pair and hold until accepted
    task automatic send_reading(logic [15:0] ut, logic [15:0] up);
        start   <= 1'b1;
        i_in    <= '{raw_temp: ut, raw_pressure: up};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        beats++;
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Wait for all results to drain, then the pipeline depth
    task automatic drain();
        pause(1);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Write one register; the caller drops the write enable afterwards
    task automatic write_cal(logic [ptc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic end_cal();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Typical calibration with or without random jitter, or fully random, all-ones or all-zero words
    task automatic load_cal(int mode);
        logic [15:0] w [0:9];
        w = '{16'd408, 16'hFE3B, 16'hC6E9, 16'd32741, 16'd32757,
              16'd23153, 16'd6190, 16'd4, 16'h8000, 16'd2868};
        for (int k = 0; k < 10; k++) begin
            if (mode == 1) w[k] = w[k] + 16'($urandom_range(0, 64)) - 16'd32;
            if (mode == 2) w[k] = 16'($urandom);
            if (mode == 3) w[k] = 16'hFFFF;
        end
        if (mode == 4) w = '{default: 16'h0000};
        write_cal(ptc_pkg::REG_AC1_AC2, {w[0], w[1]});
        write_cal(ptc_pkg::REG_AC3_AC4, {w[2], w[3]});
        write_cal(ptc_pkg::REG_AC5_AC6, {w[4], w[5]});
        write_cal(ptc_pkg::REG_B1_B2,   {w[6], w[7]});
        write_cal(ptc_pkg::REG_MC_MD,   {w[8], w[9]});
        write_cal(3'd7, 32'hDEAD_BEEF);
        end_cal();
    endtask

    task automatic random_phase(int count, int bool_typical);
        int n;
        while (count > 0) begin
            n = $urandom_range(1, 30);
            for (int k = 0; k < n && count > 0; k++) begin
                if (bool_typical != 0 && $urandom_range(0, 3) != 0)
                    send_reading(16'($urandom_range(22000, 32000)),
                                 16'($urandom_range(20000, 30000)));
                else
                    send_reading(16'($urandom), 16'($urandom));
                count--;
            end
            if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: typical set, field extremes, zero divisors
        load_cal(0);
        send_reading(16'd27898, 16'd23843);
        send_reading(16'h0000, 16'h0000);
        send_reading(16'hFFFF, 16'hFFFF);
        send_reading(16'h0000, 16'hFFFF);
        send_reading(16'hFFFF, 16'h0000);
        send_reading(16'h8000, 16'h7FFF);
        drain();
        load_cal(4);
        send_reading(16'd1234, 16'd4321);
        send_reading(16'hFFFF, 16'hFFFF);
        drain();
        // MD zero with AC5 zero: first divisor is zero
        write_cal(ptc_pkg::REG_AC5_AC6, 32'h0000_1234);
        write_cal(ptc_pkg::REG_MC_MD, 32'h1234_0000);
        end_cal();
        send_reading(16'd30000, 16'd100);
        drain();
        load_cal(3);
        send_reading(16'h0000, 16'h0000);
        send_reading(16'hFFFF, 16'hFFFF);
        send_reading(16'h5555, 16'hAAAA);
        drain();

        // Random phases across calibration sets
        for (int ph = 0; ph < 8; ph++) begin
            load_cal((ph % 3 == 2) ? 2 : 1);
            random_phase(100, (ph % 3 != 2) ? 1 : 0);
            drain();
        end

        start <= 1'b0;
        drain();
        $display("Sent %0d reading pairs over directed and random calibration sets, %0d results checked",
                 beats, results);
        $display("Covered zero-divisor, all-ones, typical and random calibration words");
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/ptc_pkg.sv
hdl/ptc_div.sv
hdl/pressure_temperature_compensation_unit.sv
verif/pressure_temperature_compensation_checker.sv
verif/pressure_temperature_compensation_unit_test.sv
